>>> design/tote_pkg.sv
// Package for the TCP option timestamp extractor.
// Holds the walk phases, status codes, option constants and the beat structs.
// No dependencies.
package tote_pkg;

  localparam int unsigned MaxAreaBytesDefault = 40;

  localparam logic [7:0] OptEol       = 8'd0;
  localparam logic [7:0] OptNop       = 8'd1;
  localparam logic [7:0] OptTimestamp = 8'd8;
  localparam logic [7:0] TsOptLen     = 8'd10;
  localparam logic [7:0] MinOptLen    = 8'd2;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_KIND = 3'd1,
    PH_LEN  = 3'd2,
    PH_SKIP = 3'd3,
    PH_TS   = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    ST_FOUND     = 3'd0,
    ST_END_LIST  = 3'd1,
    ST_LEN_SHORT = 3'd2,
    ST_OVERRUN   = 3'd3,
    ST_EXHAUSTED = 3'd4
  } status_e;

  // One input beat
  typedef struct packed {
    logic [7:0] data_byte;
    logic       area_start;
    logic [5:0] area_length;
  } item_t;

  // One result from the walker
  typedef struct packed {
    logic        valid;
    status_e     status;
    logic [31:0] ts_value;
    logic [31:0] ts_echo;
  } res_t;

endpackage

>>> design/tote_in_reg.sv
// Input register of the TCP option timestamp extractor.
// Captures one beat and holds it until the walker takes it. Uses tote_pkg.
module tote_in_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  tote_pkg::item_t item_i,
  input  logic           advance_i,
  output logic           valid_o,
  output tote_pkg::item_t item_o
);
  import tote_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;
  logic  load;

  // Stall only while a held beat cannot move on
  assign in_stall_o = valid_q && !advance_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture payload on accept
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

>>> design/tote_walker.sv
// Option walker of the TCP option timestamp extractor.
// Holds the walk state and steps it by one byte per advance. Uses tote_pkg.
module tote_walker #(
  parameter int unsigned MAX_AREA_BYTES = tote_pkg::MaxAreaBytesDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            advance_i,
  input  tote_pkg::item_t item_i,
  output tote_pkg::res_t  res_o
);
  import tote_pkg::*;

  localparam logic [5:0] MaxArea = 6'(MAX_AREA_BYTES);

  phase_e      phase_q, phase_d;
  logic [5:0]  remaining_q, remaining_d;
  logic [5:0]  skip_q, skip_d;
  logic [7:0]  kind_q, kind_d;
  logic [2:0]  index_q, index_d;
  logic [31:0] value_q, value_d;
  logic [31:0] echo_q, echo_d;

  // Step the walk by one byte
  always_comb begin
    logic       done;
    status_e    code;
    logic [7:0] b;
    logic [5:0] alen;
    logic [8:0] room;

    done        = 1'b0;
    code        = ST_EXHAUSTED;
    b           = item_i.data_byte;
    alen        = item_i.area_length;
    room        = 9'd0;
    phase_d     = phase_q;
    remaining_d = remaining_q;
    skip_d      = skip_q;
    kind_d      = kind_q;
    index_d     = index_q;
    value_d     = value_q;
    echo_d      = echo_q;

    // Open a new area, abandoning any current one
    if (item_i.area_start) begin
      if (alen > MaxArea) begin
        alen = MaxArea;
      end
      remaining_d = alen;
      skip_d      = '0;
      kind_d      = '0;
      index_d     = '0;
      value_d     = '0;
      echo_d      = '0;
      phase_d     = PH_KIND;
      if (alen == 6'd0) begin
        done = 1'b1;
        code = ST_EXHAUSTED;
      end
    end

    if (!done) begin
      unique case (phase_d)
        PH_KIND: begin
          if (b == OptEol) begin
            done = 1'b1;
            code = ST_END_LIST;
          end else begin
            remaining_d = remaining_d - 6'd1;
            if (b == OptNop) begin
              if (remaining_d == 6'd0) begin
                done = 1'b1;
                code = ST_EXHAUSTED;
              end
            end else begin
              kind_d = b;
              if (remaining_d == 6'd0) begin
                done = 1'b1;
                code = ST_OVERRUN;
              end else begin
                phase_d = PH_LEN;
              end
            end
          end
        end
        PH_LEN: begin
          room = {3'b000, remaining_d} + 9'd1;
          if (b < MinOptLen) begin
            done = 1'b1;
            code = ST_LEN_SHORT;
          end else if ({1'b0, b} > room) begin
            done = 1'b1;
            code = ST_OVERRUN;
          end else begin
            remaining_d = remaining_d - 6'd1;
            if (kind_d == OptTimestamp && b == TsOptLen) begin
              index_d = '0;
              value_d = '0;
              echo_d  = '0;
              phase_d = PH_TS;
            end else begin
              skip_d = b[5:0] - MinOptLen[5:0];
              if (skip_d == 6'd0) begin
                if (remaining_d == 6'd0) begin
                  done = 1'b1;
                  code = ST_EXHAUSTED;
                end else begin
                  phase_d = PH_KIND;
                end
              end else begin
                phase_d = PH_SKIP;
              end
            end
          end
        end
        PH_SKIP: begin
          remaining_d = remaining_d - 6'd1;
          skip_d      = skip_d - 6'd1;
          if (skip_d == 6'd0) begin
            if (remaining_d == 6'd0) begin
              done = 1'b1;
              code = ST_EXHAUSTED;
            end else begin
              phase_d = PH_KIND;
            end
          end
        end
        PH_TS: begin
          remaining_d = remaining_d - 6'd1;
          if (!index_d[2]) begin
            value_d = {value_d[23:0], b};
          end else begin
            echo_d = {echo_d[23:0], b};
          end
          index_d = index_d + 3'd1;
          if (index_d == 3'd0) begin
            done = 1'b1;
            code = ST_FOUND;
          end
        end
        default: begin
          // idle: drop bytes outside an area
        end
      endcase
    end

    if (done) begin
      phase_d = PH_IDLE;
    end

    res_o.valid    = done;
    res_o.status   = code;
    res_o.ts_value = (done && code == ST_FOUND) ? value_d : 32'd0;
    res_o.ts_echo  = (done && code == ST_FOUND) ? echo_d : 32'd0;
  end

  // Advance the walk state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      remaining_q <= '0;
      skip_q      <= '0;
      kind_q      <= '0;
      index_q     <= '0;
      value_q     <= '0;
      echo_q      <= '0;
    end else if (advance_i) begin
      phase_q     <= phase_d;
      remaining_q <= remaining_d;
      skip_q      <= skip_d;
      kind_q      <= kind_d;
      index_q     <= index_d;
      value_q     <= value_d;
      echo_q      <= echo_d;
    end
  end

endmodule

>>> design/tote_out_reg.sv
// Result register of the TCP option timestamp extractor.
// Holds one result beat until the consumer takes it. Uses tote_pkg.
module tote_out_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  tote_pkg::res_t res_i,
  input  logic           out_stall_i,
  output logic           out_valid_o,
  output tote_pkg::res_t res_o
);
  import tote_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;

  // Keep a result until it is taken, then free or reload
  assign valid_d = load_i ? 1'b1 : (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

>>> design/tcp_option_timestamp_extractor.sv
// TCP option timestamp extractor, top level.
// Built from tote_in_reg, tote_walker and tote_out_reg; uses tote_pkg.
//
// Takes one byte of a TCP option area per beat and sustains one beat per
// cycle while no held result is stalled at the output. Each byte passes an
// input register, the walker's step that updates the walk state and, when it
// ends the area's walk, a result register. Each area gives one result: the
// timestamp value and echo of the first kind 8 length 10 option, or a stop
// status (end of list, short length, overrun, area exhausted). An area length
// above MAX_AREA_BYTES is clamped. Input is stalled only while a held result
// is stalled at the output.
module tcp_option_timestamp_extractor #(
  parameter int unsigned MAX_AREA_BYTES = tote_pkg::MaxAreaBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        area_start_i,
  input  logic [5:0]  area_length_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [31:0] ts_value_o,
  output logic [31:0] ts_echo_o
);
  import tote_pkg::*;

  item_t item_in, item_held;
  logic  held_valid;
  logic  advance;
  res_t  step_res, out_res;
  logic  out_valid;

  assign item_in.data_byte   = data_byte_i;
  assign item_in.area_start  = area_start_i;
  assign item_in.area_length = area_length_i;

  // Move the held byte on when the result register can take a result
  assign advance = held_valid && (!out_valid || !out_stall_i);

  tote_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (item_in),
    .advance_i  (advance),
    .valid_o    (held_valid),
    .item_o     (item_held)
  );

  tote_walker #(
    .MAX_AREA_BYTES (MAX_AREA_BYTES)
  ) u_walker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (item_held),
    .res_o     (step_res)
  );

  tote_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && step_res.valid),
    .res_i       (step_res),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid),
    .res_o       (out_res)
  );

  assign out_valid_o = out_valid;
  assign status_o    = out_res.status;
  assign ts_value_o  = out_res.ts_value;
  assign ts_echo_o   = out_res.ts_echo;

endmodule

>>> tb/tb_top.sv
// Testbench for tcp_option_timestamp_extractor: random TCP option areas in,
// every result checked against a cycle-free walk of the same byte stream.
// Depends on tote_pkg and the extractor top level.
module tb_top;
  import tote_pkg::*;

  localparam int MaxArea      = MaxAreaBytesDefault;
  localparam int StreamBeats  = 880;
  localparam int IdleLimit    = 2000;
  localparam int HoldCycles   = 300;

  // Expected outcome of one option area
  typedef struct packed {
    status_e     status;
    logic [31:0] value;
    logic [31:0] echo;
  } area_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = '0;
  logic        area_start_i = 1'b0;
  logic [5:0]  area_length_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  status_o;
  logic [31:0] ts_value_o;
  logic [31:0] ts_echo_o;

  tcp_option_timestamp_extractor u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .area_start_i  (area_start_i),
    .area_length_i (area_length_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .ts_value_o    (ts_value_o),
    .ts_echo_o     (ts_echo_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  item_t        option_bytes_q[$];
  logic [7:0]   area_body[$];
  area_result_t pending_ts_results[$];
  int           n_err = 0;

  // Walker state mirrored by the predictor
  phase_e      w_phase;
  logic [5:0]  w_remaining;
  logic [5:0]  w_skip;
  logic [7:0]  w_kind;
  logic [2:0]  w_index;
  logic [31:0] w_value;
  logic [31:0] w_echo;

  // End the walk of the current area and report its outcome
  function automatic bit close_area(input status_e code, output area_result_t r);
    r.status = code;
    r.value  = (code == ST_FOUND) ? w_value : 32'd0;
    r.echo   = (code == ST_FOUND) ? w_echo : 32'd0;
    w_phase  = PH_IDLE;
    return 1'b1;
  endfunction

  // Advance the option walk by one byte; return 1 when the area is decided
  function automatic bit walk_option_byte(input item_t it, output area_result_t r);
    logic [7:0] b;
    b = it.data_byte;
    r = '0;
    if (it.area_start) begin
      w_remaining = (it.area_length > MaxArea) ? 6'(MaxArea) : it.area_length;
      w_skip  = '0;
      w_kind  = '0;
      w_index = '0;
      w_value = '0;
      w_echo  = '0;
      w_phase = PH_KIND;
      if (w_remaining == 0) return close_area(ST_EXHAUSTED, r);
    end
    case (w_phase)
      PH_KIND: begin
        if (b == OptEol) return close_area(ST_END_LIST, r);
        w_remaining = w_remaining - 6'd1;
        if (b == OptNop) begin
          if (w_remaining == 0) return close_area(ST_EXHAUSTED, r);
          return 1'b0;
        end
        w_kind = b;
        // a kind with no room left for its length byte
        if (w_remaining == 0) return close_area(ST_OVERRUN, r);
        w_phase = PH_LEN;
      end
      PH_LEN: begin
        if (b < MinOptLen) return close_area(ST_LEN_SHORT, r);
        if (int'(b) > int'(w_remaining) + 1) return close_area(ST_OVERRUN, r);
        w_remaining = w_remaining - 6'd1;
        if (w_kind == OptTimestamp && b == TsOptLen) begin
          w_index = '0;
          w_value = '0;
          w_echo  = '0;
          w_phase = PH_TS;
        end else begin
          w_skip = 6'(b - MinOptLen);
          if (w_skip == 0) begin
            if (w_remaining == 0) return close_area(ST_EXHAUSTED, r);
            w_phase = PH_KIND;
          end else begin
            w_phase = PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        w_remaining = w_remaining - 6'd1;
        w_skip = w_skip - 6'd1;
        if (w_skip == 0) begin
          if (w_remaining == 0) return close_area(ST_EXHAUSTED, r);
          w_phase = PH_KIND;
        end
      end
      PH_TS: begin
        w_remaining = w_remaining - 6'd1;
        if (w_index < 3'd4) w_value = {w_value[23:0], b};
        else w_echo = {w_echo[23:0], b};
        w_index = w_index + 3'd1;
        if (w_index == 0) return close_area(ST_FOUND, r);
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  task automatic add_beat(input logic [7:0] b, input logic s, input logic [5:0] l);
    item_t it;
    it.data_byte   = b;
    it.area_start  = s;
    it.area_length = l;
    option_bytes_q.push_back(it);
  endtask

  // Queue the collected area bytes; only the first beat carries the length
  task automatic flush_area(input logic [5:0] len);
    for (int i = 0; i < area_body.size(); i++) begin
      add_beat(area_body[i], i == 0, (i == 0) ? len : 6'($urandom));
    end
  endtask

  // Build one random area: mostly well-formed options, some corrupted
  task automatic gen_area();
    logic [5:0] len;
    logic [7:0] kind;
    int room;
    int k;
    int olen;
    area_body.delete();
    if ($urandom_range(0, 99) < 6) len = 6'($urandom_range(MaxArea + 1, 63));
    else len = 6'($urandom_range(1, MaxArea));
    room = (len > MaxArea) ? MaxArea : len;
    while (room > 0) begin
      k = $urandom_range(0, 99);
      if (k < 15) begin
        area_body.push_back(OptNop);
        room--;
      end else if (k < 40 && room >= 10) begin
        area_body.push_back(OptTimestamp);
        area_body.push_back(TsOptLen);
        repeat (8) area_body.push_back(8'($urandom));
        room -= 10;
      end else if (k < 45) begin
        area_body.push_back(OptEol);
        room--;
      end else if (room >= 2) begin
        if ($urandom_range(0, 9) == 0) kind = OptTimestamp;
        else kind = 8'($urandom_range(2, 255));
        if (kind == OptTimestamp && $urandom_range(0, 9) != 0) kind = 8'd9;
        olen = $urandom_range(2, (room < 12) ? room : 12);
        area_body.push_back(kind);
        area_body.push_back(8'(olen));
        repeat (olen - 2) area_body.push_back(8'($urandom));
        room -= olen;
      end else begin
        area_body.push_back(8'($urandom_range(2, 255)));
        room--;
      end
    end
    k = $urandom_range(0, 99);
    if (k < 12) begin
      // overwrite one byte with a length-like or random value
      case ($urandom_range(0, 3))
        0: area_body[$urandom_range(0, area_body.size() - 1)] = 8'd0;
        1: area_body[$urandom_range(0, area_body.size() - 1)] = 8'd1;
        2: area_body[$urandom_range(0, area_body.size() - 1)] = 8'($urandom_range(0, 63));
        default: area_body[$urandom_range(0, area_body.size() - 1)] = 8'($urandom);
      endcase
    end else if (k < 18) begin
      // cut the area short so the next start abandons it
      olen = $urandom_range(1, area_body.size());
      while (area_body.size() > olen) void'(area_body.pop_back());
    end else if (k < 22) begin
      foreach (area_body[i]) area_body[i] = 8'($urandom);
    end
    flush_area(len);
    // trailing or stray beats outside any area
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 3)) add_beat(8'($urandom), 1'b0, 6'($urandom));
    end
  endtask

  // Stimulus: directed areas first, then random ones
  initial begin
    add_beat(8'hFF, 1'b0, 6'h3F);
    area_body = '{OptEol};
    flush_area(6'd1);
    area_body = '{8'd5, 8'd1};
    flush_area(6'd2);
    area_body = '{8'd5, 8'd9};
    flush_area(6'd3);
    area_body = '{8'd5};
    flush_area(6'd1);
    area_body = '{OptNop, 8'd2, 8'd2};
    flush_area(6'd3);
    area_body = '{OptNop};
    flush_area(6'd63);
    area_body = '{OptTimestamp, TsOptLen, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                  8'h00, 8'h00, 8'h00, 8'h00};
    flush_area(6'd10);
    while (option_bytes_q.size() < StreamBeats) gen_area();

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Wait for the last beat to be taken and every result to drain
    @(negedge clk_i);
    while (option_bytes_q.size() != 0 || in_valid_i || pending_ts_results.size() != 0)
      @(negedge clk_i);
    repeat (12) @(posedge clk_i);
    if (n_err == 0) begin
      $display("** tcp_option_timestamp_extractor: PASSED **");
    end else begin
      $display("** tcp_option_timestamp_extractor: FAILED **");
    end
    $finish;
  end

  // Driver: offer queued beats with random gaps between them
  int gap_left;
  int send_calm;

  always @(posedge clk_i or negedge rst_ni) begin : drv
    item_t nxt;
    int k;
    if (!rst_ni) begin
      in_valid_i    <= 1'b0;
      data_byte_i   <= '0;
      area_start_i  <= 1'b0;
      area_length_i <= '0;
      gap_left = 0;
      send_calm = 0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (option_bytes_q.size() > 0) begin
        nxt = option_bytes_q.pop_front();
        in_valid_i    <= 1'b1;
        data_byte_i   <= nxt.data_byte;
        area_start_i  <= nxt.area_start;
        area_length_i <= nxt.area_length;
        // pick the gap that follows this beat
        if (send_calm > 0) begin
          send_calm--;
        end else begin
          k = $urandom_range(0, 99);
          if (k < 60) gap_left = 0;
          else if (k < 85) gap_left = $urandom_range(1, 3);
          else if (k < 90) send_calm = $urandom_range(30, 100);
          else if (k < 97) gap_left = $urandom_range(4, 8);
          else gap_left = $urandom_range(15, 40);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: predict on each accepted input beat, check each result beat
  int stall_run;
  logic stall_lvl;
  int hold_left;
  int next_hold_at;
  int in_seen;

  always @(posedge clk_i or negedge rst_ni) begin : mon
    area_result_t want;
    area_result_t fresh;
    item_t it;
    logic nstall;
    int k;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      w_phase     = PH_IDLE;
      w_remaining = '0;
      w_skip      = '0;
      w_kind      = '0;
      w_index     = '0;
      w_value     = '0;
      w_echo      = '0;
      stall_run    = 0;
      stall_lvl    = 1'b0;
      hold_left    = 0;
      next_hold_at = 400;
      in_seen      = 0;
    end else begin
      // Check the result beat against the oldest expectation
      if (out_valid_o && !out_stall_i) begin
        if (pending_ts_results.size() == 0) begin
          n_err++;
          $display("%0t: unexpected result: expected none, actual status %0d",
                   $time, status_o);
        end else begin
          want = pending_ts_results.pop_front();
          if (status_o !== want.status) begin
            n_err++;
            $display("%0t: status expected %0d, actual %0d", $time, want.status, status_o);
          end
          if (ts_value_o !== want.value) begin
            n_err++;
            $display("%0t: ts_value expected %h, actual %h", $time, want.value, ts_value_o);
          end
          if (ts_echo_o !== want.echo) begin
            n_err++;
            $display("%0t: ts_echo expected %h, actual %h", $time, want.echo, ts_echo_o);
          end
        end
      end
      // Predict on the accepted input beat
      if (in_valid_i && !in_stall_o) begin
        in_seen++;
        it.data_byte   = data_byte_i;
        it.area_start  = area_start_i;
        it.area_length = area_length_i;
        if (walk_option_byte(it, fresh)) pending_ts_results.push_back(fresh);
      end
      // Choose the stall for the next cycle; hold off long now and then
      if (hold_left > 0) begin
        hold_left--;
        nstall = 1'b1;
      end else if (in_seen >= next_hold_at) begin
        next_hold_at += 500;
        hold_left = HoldCycles - 1;
        nstall = 1'b1;
      end else begin
        if (stall_run == 0) begin
          k = $urandom_range(0, 99);
          if (k < 50) begin
            stall_lvl = 1'b0;
            stall_run = $urandom_range(1, 6);
          end else if (k < 80) begin
            stall_lvl = 1'b1;
            stall_run = $urandom_range(1, 3);
          end else if (k < 92) begin
            stall_lvl = 1'b0;
            stall_run = $urandom_range(40, 120);
          end else begin
            stall_lvl = 1'b1;
            stall_run = $urandom_range(10, 40);
          end
        end
        stall_run--;
        nstall = stall_lvl;
      end
      out_stall_i <= nstall;
    end
  end

  // Watchdog: end the run when no beat moves on either side for too long
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("** tcp_option_timestamp_extractor: FAILED **");
        $finish;
      end
    end
  end

endmodule
